// ===== design/ibmh_pkg.sv =====
package ibmh_pkg;

    localparam logic [1:0] ACT_INIT = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;
    localparam logic [1:0] ACT_DEC  = 2'd2;
    localparam logic [1:0] ACT_GET  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BADKEY = 2'd2;

    localparam logic [30:0] INF_DIST = 31'h7FFF_FFFF;

    localparam int DIST_W = 31;
    localparam int KEY_W  = 8;

    // label and slot widths are tied to the 8-bit key ports
    localparam int MAX_NODES = 256;

endpackage

// ===== design/ibmh_store.sv =====
// Heap slot storage: one row holds distance and label; separate label position table.
module ibmh_store #(
    parameter int MAX_NODES = 256,
    parameter int AW = 8
) (
    input  logic                      clk,
    input  logic                      hwe,
    input  logic [AW-1:0]             hwaddr,
    input  logic [ibmh_pkg::DIST_W-1:0] hwdist,
    input  logic [AW-1:0]             hwlab,
    input  logic [AW-1:0]             hraddr,
    output logic [ibmh_pkg::DIST_W-1:0] hrdist,
    output logic [AW-1:0]             hrlab,
    input  logic                      pwe,
    input  logic [AW-1:0]             pwaddr,
    input  logic [AW-1:0]             pwdata,
    input  logic [AW-1:0]             praddr,
    output logic [AW-1:0]             prdata
);
    logic [ibmh_pkg::DIST_W-1:0] dist_mem [MAX_NODES];
    logic [AW-1:0]               lab_mem  [MAX_NODES];
    logic [AW-1:0]               pos_mem  [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (hwe)
        begin
            dist_mem[hwaddr] <= hwdist;
            lab_mem[hwaddr]  <= hwlab;
        end
        hrdist <= dist_mem[hraddr];
        hrlab  <= lab_mem[hraddr];
    end

    always_ff @(posedge clk)
    begin
        if (pwe)
            pos_mem[pwaddr] <= pwdata;
        prdata <= pos_mem[praddr];
    end
endmodule

// ===== design/indexed_binary_min_heap_top.sv =====
// Get looks up the label's slot and reads it; decrease-key does the same and then
// sifts up; pop takes the root, moves the last slot into it and sifts down; init
// fills node_count slots, then sifts the source slot up and down.
// One transaction at a time; in_ready is low while an item is in work or a result waits.
// Each table has a single read port, and the sequencer steps through the reads in turn.
// rst_n (async, low) empties the heap and sets node_count to 256;
// table contents stay undefined until an init writes them.
module indexed_binary_min_heap_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  node_key,
    input  logic [30:0] new_distance,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [30:0] out_distance,
    output logic [7:0]  out_label,
    output logic [1:0]  status
);
    localparam int MAX_NODES = ibmh_pkg::MAX_NODES;
    localparam int AW = $clog2(MAX_NODES);
    localparam int CW = AW + 1;
    localparam int DW = ibmh_pkg::DIST_W;

    typedef enum logic [4:0] {
        S_IDLE, S_FILL, S_SRC,
        S_UP_RD, S_UP_W1, S_UP_RP, S_UP_W2, S_UP_CMP,
        S_DN_RD, S_DN_W1, S_DN_RL, S_DN_W2, S_DN_RR, S_DN_W3, S_DN_CMP,
        S_SWAP, S_SWAP2,
        S_POP_RD, S_POP_W, S_POP_RL, S_POP_W2, S_POP_MV,
        S_LK_RD, S_LK_W1, S_LK_RH, S_LK_W2, S_LK_CHK,
        S_OUT
    } state_t;

    state_t state_reg;
    logic [8:0]    ncount_reg;
    logic [CW-1:0] hcount_reg;
    logic [1:0]    act_reg;
    logic [7:0]    key_reg;
    logic [DW-1:0] ndist_reg;
    logic [CW-1:0] idx_reg;     // current slot (also fill counter)
    logic [CW-1:0] oth_reg;     // parent or chosen child
    logic [DW-1:0] di_reg, dx_reg, dl_reg;
    logic [AW-1:0] li_reg, lx_reg, ll_reg;
    logic          down_after_reg;
    logic [DW-1:0] od_reg;
    logic [7:0]    ol_reg;
    logic [1:0]    st_reg;
    logic          ov_reg;

    logic          hwe, pwe;
    logic [AW-1:0] hwaddr, hwlab, hraddr, pwaddr, pwdata_i, praddr, hrlab, prdata_i;
    logic [DW-1:0] hwdist, hrdist;

    ibmh_store #(.MAX_NODES(MAX_NODES), .AW(AW)) u_store (
        .clk(clk), .hwe(hwe), .hwaddr(hwaddr), .hwdist(hwdist), .hwlab(hwlab),
        .hraddr(hraddr), .hrdist(hrdist), .hrlab(hrlab),
        .pwe(pwe), .pwaddr(pwaddr), .pwdata(pwdata_i), .praddr(praddr),
        .prdata(prdata_i)
    );

    logic [CW-1:0] n_eff;
    logic [CW:0]   lch;
    assign n_eff = (ncount_reg > 9'(MAX_NODES)) ? CW'(MAX_NODES)
                                                  : CW'(ncount_reg);
    assign lch = {idx_reg, 1'b1};   // 2*i+1

    assign pready = 1'b1;
    assign prdata = {23'd0, ncount_reg};
    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_distance = od_reg;
    assign out_label = ol_reg;
    assign status = st_reg;

    // child index is above the current one when walking down
    function automatic logic state_is_down(logic [CW-1:0] a, logic [CW-1:0] b);
        return a > b;
    endfunction

    // memory port control
    always_comb
    begin
        hwe = 1'b0; pwe = 1'b0;
        hwaddr = idx_reg[AW-1:0]; hwdist = ibmh_pkg::INF_DIST; hwlab = idx_reg[AW-1:0];
        pwaddr = idx_reg[AW-1:0]; pwdata_i = idx_reg[AW-1:0];
        hraddr = idx_reg[AW-1:0]; praddr = key_reg[AW-1:0];
        unique case (state_reg)
            S_FILL:
            begin
                hwe = 1'b1; pwe = 1'b1;
            end
            S_SRC:
            begin
                hwe = 1'b1; hwdist = '0;
            end
            S_UP_RP, S_UP_W2: hraddr = oth_reg[AW-1:0];
            S_DN_RL: hraddr = oth_reg[AW-1:0];
            S_DN_RR: hraddr = oth_reg[AW-1:0] + AW'(1);
            S_POP_RL: hraddr = AW'(hcount_reg - CW'(1));
            S_POP_MV:
            begin
                // move last into root and point its position entry at the root
                hwe = 1'b1; hwaddr = '0; hwdist = dx_reg; hwlab = lx_reg;
                pwe = 1'b1; pwaddr = lx_reg; pwdata_i = '0;
            end
            S_LK_RH, S_LK_W2: hraddr = prdata_i;
            S_SWAP:
            begin
                hwe = 1'b1; hwaddr = idx_reg[AW-1:0]; hwdist = dx_reg; hwlab = lx_reg;
                pwe = 1'b1; pwaddr = lx_reg; pwdata_i = idx_reg[AW-1:0];
            end
            S_SWAP2:
            begin
                hwe = 1'b1; hwaddr = oth_reg[AW-1:0]; hwdist = di_reg; hwlab = li_reg;
                pwe = 1'b1; pwaddr = li_reg; pwdata_i = oth_reg[AW-1:0];
            end
            S_DN_CMP, S_UP_CMP:
            begin
                hwdist = ndist_reg;
            end
            S_LK_CHK:
            begin
                if (act_reg == ibmh_pkg::ACT_DEC && CW'(prdata_i) < hcount_reg
                    && hrlab == key_reg[AW-1:0])
                begin
                    hwe = 1'b1; hwaddr = prdata_i; hwdist = ndist_reg;
                    hwlab = key_reg[AW-1:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ncount_reg <= 9'd256;
            hcount_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == 2'd0)
                ncount_reg <= pwdata[8:0];
            if (ov_reg && out_ready)
                ov_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                    begin
                        act_reg <= action; key_reg <= node_key; ndist_reg <= new_distance;
                        od_reg <= '0; ol_reg <= node_key; st_reg <= ibmh_pkg::ST_OK;
                        idx_reg <= '0;
                        unique case (action)
                            ibmh_pkg::ACT_INIT:
                                if (CW'(node_key) >= n_eff || node_key > 8'(MAX_NODES - 1))
                                begin
                                    st_reg <= ibmh_pkg::ST_BADKEY; state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_FILL;
                            ibmh_pkg::ACT_POP:
                                if (hcount_reg == '0)
                                begin
                                    st_reg <= ibmh_pkg::ST_EMPTY; ol_reg <= '0;
                                    state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_POP_RD;
                            default:
                                if (node_key > 8'(MAX_NODES - 1))
                                begin
                                    st_reg <= ibmh_pkg::ST_BADKEY; state_reg <= S_OUT;
                                end
                                else
                                    state_reg <= S_LK_RD;
                        endcase
                    end
                S_FILL:
                    if (idx_reg == n_eff - CW'(1))
                    begin
                        hcount_reg <= n_eff; state_reg <= S_SRC;
                        idx_reg <= CW'(key_reg);
                    end
                    else
                        idx_reg <= idx_reg + CW'(1);
                S_SRC:
                begin
                    down_after_reg <= 1'b1; state_reg <= S_UP_RD;
                end
                // sift up: slot idx vs parent; init then sifts down from the source slot
                S_UP_RD:
                    if (idx_reg == '0)
                    begin
                        if (down_after_reg)
                        begin
                            idx_reg <= CW'(key_reg); state_reg <= S_DN_RD;
                        end
                        else
                            state_reg <= S_OUT;
                    end
                    else
                    begin
                        oth_reg <= (idx_reg - CW'(1)) >> 1; state_reg <= S_UP_W1;
                    end
                S_UP_W1:
                    state_reg <= S_UP_RP;
                S_UP_RP:
                begin
                    di_reg <= hrdist; li_reg <= hrlab; state_reg <= S_UP_W2;
                end
                S_UP_W2:
                    state_reg <= S_UP_CMP;
                S_UP_CMP:
                    if (di_reg <= hrdist)
                    begin
                        // idx gets parent contents, parent gets child
                        dx_reg <= hrdist; lx_reg <= hrlab; state_reg <= S_SWAP;
                    end
                    else if (down_after_reg)
                    begin
                        idx_reg <= CW'(key_reg); state_reg <= S_DN_RD;
                    end
                    else
                        state_reg <= S_OUT;
                S_DN_RD:
                    if (lch >= (CW+1)'(hcount_reg))
                        state_reg <= S_OUT;
                    else
                    begin
                        oth_reg <= lch[CW-1:0]; state_reg <= S_DN_W1;
                    end
                S_DN_W1:
                    state_reg <= S_DN_RL;
                S_DN_RL:
                begin
                    di_reg <= hrdist; li_reg <= hrlab; state_reg <= S_DN_W2;
                end
                S_DN_W2:
                begin
                    dl_reg <= hrdist; ll_reg <= hrlab;
                    if (oth_reg + CW'(1) < hcount_reg)
                        state_reg <= S_DN_RR;
                    else
                    begin
                        dx_reg <= hrdist; lx_reg <= hrlab; state_reg <= S_DN_CMP;
                    end
                end
                S_DN_RR:
                    state_reg <= S_DN_W3;
                S_DN_W3:
                begin
                    if (dl_reg < hrdist)
                    begin
                        dx_reg <= dl_reg; lx_reg <= ll_reg;
                    end
                    else
                    begin
                        dx_reg <= hrdist; lx_reg <= hrlab; oth_reg <= oth_reg + CW'(1);
                    end
                    state_reg <= S_DN_CMP;
                end
                S_DN_CMP:
                    if (di_reg < dx_reg)
                        state_reg <= S_OUT;
                    else
                        state_reg <= S_SWAP;
                S_SWAP:
                    state_reg <= S_SWAP2;
                S_SWAP2:
                begin
                    idx_reg <= oth_reg;
                    if (down_after_reg && state_is_down(oth_reg, idx_reg))
                        state_reg <= S_DN_RD;
                    else
                        state_reg <= S_UP_RD;
                end
                // pop
                S_POP_RD:
                    state_reg <= S_POP_W;
                S_POP_W:
                begin
                    od_reg <= hrdist; ol_reg <= 8'(hrlab); state_reg <= S_POP_RL;
                end
                S_POP_RL:
                    state_reg <= S_POP_W2;
                S_POP_W2:
                begin
                    dx_reg <= hrdist; lx_reg <= hrlab; state_reg <= S_POP_MV;
                end
                S_POP_MV:
                begin
                    hcount_reg <= hcount_reg - CW'(1);
                    idx_reg <= '0; down_after_reg <= 1'b1; state_reg <= S_DN_RD;
                end
                // lookup for decrease / get
                S_LK_RD:
                    state_reg <= S_LK_W1;
                S_LK_W1:
                    state_reg <= S_LK_RH;
                S_LK_RH:
                    state_reg <= S_LK_W2;
                S_LK_W2:
                    state_reg <= S_LK_CHK;
                S_LK_CHK:
                    if (!(CW'(prdata_i) < hcount_reg && hrlab == key_reg[AW-1:0]))
                    begin
                        st_reg <= ibmh_pkg::ST_BADKEY; state_reg <= S_OUT;
                    end
                    else if (act_reg == ibmh_pkg::ACT_GET)
                    begin
                        od_reg <= hrdist; state_reg <= S_OUT;
                    end
                    else
                    begin
                        od_reg <= ndist_reg; idx_reg <= CW'(prdata_i);
                        down_after_reg <= 1'b0; state_reg <= S_UP_RD;
                    end
                S_OUT:
                    if (!ov_reg || out_ready)
                    begin
                        ov_reg <= 1'b1; state_reg <= S_IDLE;
                    end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== design/ibmh_checker.sv =====
module ibmh_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic [30:0] out_distance,
    input logic [7:0]  out_label
);
    // no new transaction while a result is pending
    a_ready_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("in_ready with result pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_distance)
        && $stable(out_label) && $stable(status)) else $error("result changed");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ibmh_pkg::ST_BADKEY) else $error("bad status");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ibmh_pkg::ST_OK |-> out_distance == '0)
        else $error("error result carries distance");

    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid) else $error("result too early");
endmodule

bind indexed_binary_min_heap_top ibmh_checker u_ibmh_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .out_distance(out_distance), .out_label(out_label)
);

// ===== tb/indexed_binary_min_heap_top_tb.sv =====
`timescale 1ns / 100ps

module indexed_binary_min_heap_top_tb;

    typedef struct packed {
        logic [1:0]  act;
        logic [7:0]  key;
        logic [30:0] dval;
    } heap_cmd_t;

    typedef struct packed {
        logic [30:0] dval;
        logic [7:0]  label;
        logic [1:0]  st;
    } heap_resp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = 2'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  action = ibmh_pkg::ACT_POP;
    logic [7:0]  node_key = 8'd0;
    logic [30:0] new_distance = 31'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [30:0] out_distance;
    logic [7:0]  out_label;
    logic [1:0]  status;

    indexed_binary_min_heap_top dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .node_key(node_key), .new_distance(new_distance),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_distance(out_distance), .out_label(out_label), .status(status)
    );

    always #10 clk = ~clk;

    // shadow heap
    logic [30:0] sh_dist [256];
    logic [7:0]  sh_label [256];
    int          sh_pos [256];
    int          sh_count = 0;
    int          sh_ncfg = 256;

    heap_cmd_t   pending_cmds [$];
    heap_resp_t  expected_resps [$];
    int          fail_count = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    bit          no_idle = 0;
    bit          tx_active = 0;

    // generator-side view of which labels have ever been written
    int          gen_ncfg = 256;
    int          gen_written = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle) return 0;
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void sh_swap(int a, int b);
        logic [7:0]  la;
        logic [7:0]  lb;
        int          t;
        logic [30:0] d;
        la = sh_label[a];
        lb = sh_label[b];
        t = sh_pos[la]; sh_pos[la] = sh_pos[lb]; sh_pos[lb] = t;
        d = sh_dist[a]; sh_dist[a] = sh_dist[b]; sh_dist[b] = d;
        sh_label[a] = lb;
        sh_label[b] = la;
    endfunction

    function automatic void sh_sift_up(int i);
        int p;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (sh_dist[i] > sh_dist[p]) break;
            sh_swap(i, p);
            i = p;
        end
    endfunction

    function automatic void sh_sift_down(int i);
        int l;
        int r;
        int x;
        while (i < sh_count) begin
            l = 2 * i + 1;
            r = 2 * i + 2;
            if (r < sh_count) x = (sh_dist[l] < sh_dist[r]) ? l : r;
            else if (l < sh_count) x = l;
            else break;
            if (sh_dist[i] < sh_dist[x]) break;
            sh_swap(i, x);
            i = x;
        end
    endfunction

    function automatic bit sh_present(logic [7:0] k);
        return sh_pos[k] < sh_count && sh_label[sh_pos[k]] == k;
    endfunction

    function automatic void heap_predict(heap_cmd_t c);
        heap_resp_t e;
        int n;
        e.dval = 31'd0;
        e.label = c.key;
        e.st = ibmh_pkg::ST_OK;
        n = (sh_ncfg > 256) ? 256 : sh_ncfg;
        case (c.act)
            ibmh_pkg::ACT_INIT: begin
                if (c.key >= n) e.st = ibmh_pkg::ST_BADKEY;
                else begin
                    for (int i = 0; i < n; i++) begin
                        sh_dist[i] = ibmh_pkg::INF_DIST;
                        sh_label[i] = i[7:0];
                        sh_pos[i] = i;
                    end
                    sh_count = n;
                    sh_dist[c.key] = 31'd0;
                    sh_sift_up(c.key);
                    sh_sift_down(c.key);
                end
            end
            ibmh_pkg::ACT_POP: begin
                if (sh_count == 0) begin
                    e.st = ibmh_pkg::ST_EMPTY;
                    e.label = 8'd0;
                end else begin
                    e.dval = sh_dist[0];
                    e.label = sh_label[0];
                    sh_swap(0, sh_count - 1);
                    sh_count = sh_count - 1;
                    sh_sift_down(0);
                end
            end
            ibmh_pkg::ACT_DEC: begin
                if (!sh_present(c.key)) e.st = ibmh_pkg::ST_BADKEY;
                else begin
                    sh_dist[sh_pos[c.key]] = c.dval;
                    sh_sift_up(sh_pos[c.key]);
                    e.dval = c.dval;
                end
            end
            default: begin
                if (!sh_present(c.key)) e.st = ibmh_pkg::ST_BADKEY;
                else e.dval = sh_dist[sh_pos[c.key]];
            end
        endcase
        expected_resps.insert(expected_resps.size(), e);
    endfunction

    // driver
    always @(posedge clk) begin
        heap_cmd_t c;
        bit        busy;
        busy = in_valid;
        if (in_valid && in_ready) begin
            heap_predict('{action, node_key, new_distance});
            busy = 0;
            tx_active = 0;
            send_gap = pick_gap();
        end
        if (rst_n && !busy) begin
            if (send_gap > 0) begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                c = pending_cmds.pop_front();
                tx_active = 1;
                action <= c.act;
                node_key <= c.key;
                new_distance <= c.dval;
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk) begin
        heap_resp_t e;
        if (out_valid && out_ready) begin
            if (expected_resps.size() == 0) begin
                $error("unexpected result: dist %0d label %0d status %0d",
                       out_distance, out_label, status);
                fail_count++;
            end else begin
                e = expected_resps.pop_front();
                if (out_distance !== e.dval) begin
                    $error("out_distance expected %0d actual %0d", e.dval, out_distance);
                    fail_count++;
                end
                if (out_label !== e.label) begin
                    $error("out_label expected %0d actual %0d", e.label, out_label);
                    fail_count++;
                end
                if (status !== e.st) begin
                    $error("status expected %0d actual %0d", e.st, status);
                    fail_count++;
                end
            end
        end
        if (recv_gap > 0) begin
            recv_gap--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= rst_n;
            if (rst_n && !out_ready) recv_gap = 0;
            else if (rst_n) recv_gap = pick_gap();
        end
    end

    task automatic push_cmd(logic [1:0] a, logic [7:0] k, logic [30:0] d);
        int n;
        n = (gen_ncfg > 256) ? 256 : gen_ncfg;
        if (a == ibmh_pkg::ACT_INIT && k < n && n > gen_written) gen_written = n;
        pending_cmds.insert(pending_cmds.size(), '{a, k, d});
    endtask

    task automatic drain();
        while (pending_cmds.size() > 0 || in_valid || tx_active
               || expected_resps.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_node_count(int v);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 2'd0;
        pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sh_ncfg = v & 9'h1FF;
        gen_ncfg = sh_ncfg;
    endtask

    function automatic logic [30:0] rand_dist();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 31'($urandom_range(0, 7));
        if (r < 6) return 31'($urandom_range(0, 1000));
        if (r == 6) return ibmh_pkg::INF_DIST;
        if (r == 7) return ibmh_pkg::INF_DIST - 31'($urandom_range(0, 2));
        return 31'($urandom());
    endfunction

    task automatic random_phase(int items);
        int n;
        int r;
        int kmax;
        n = (gen_ncfg > 256) ? 256 : gen_ncfg;
        if (n > 0)
            push_cmd(ibmh_pkg::ACT_INIT, 8'($urandom_range(0, n - 1)), 31'($urandom()));
        for (int i = 0; i < items; i++) begin
            r = $urandom_range(0, 99);
            kmax = (n > 0 && n <= gen_written) ? n - 1 : gen_written - 1;
            if (r < 35 || gen_written == 0) begin
                if (r < 90 || n == 0)
                    push_cmd(ibmh_pkg::ACT_POP, 8'($urandom()), 31'($urandom()));
                else
                    push_cmd(ibmh_pkg::ACT_INIT, 8'($urandom_range(0, n - 1)),
                             31'($urandom()));
            end else if (r < 65) begin
                push_cmd(ibmh_pkg::ACT_DEC, 8'($urandom_range(0, kmax)), rand_dist());
            end else if (r < 88) begin
                push_cmd(ibmh_pkg::ACT_GET, 8'($urandom_range(0, kmax)), 31'($urandom()));
            end else if (r < 93) begin
                if (n > 0)
                    push_cmd(ibmh_pkg::ACT_INIT, 8'($urandom_range(0, n - 1)),
                             31'($urandom()));
            end else begin
                // noise: stale or popped labels, bad init sources
                if (n < 256 && (r & 1))
                    push_cmd(ibmh_pkg::ACT_INIT, 8'($urandom_range(n, 255)),
                             31'($urandom()));
                else
                    push_cmd(ibmh_pkg::ACT_GET, 8'($urandom_range(0, gen_written - 1)),
                             31'($urandom()));
            end
        end
    endtask

    initial begin
        int cfgs [14] = '{1, 5, 16, 0, 300, 2, 3, 8, 511, 12, 256, 31, 64, 7};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty pop, extremes, ties, stale labels, larger decrease
        push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_INIT, 8'd255, 31'd0);
        push_cmd(ibmh_pkg::ACT_GET, 8'd255, 31'd0);
        push_cmd(ibmh_pkg::ACT_GET, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd0, ibmh_pkg::INF_DIST);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd3, 31'd0);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd200, 31'd0);
        push_cmd(ibmh_pkg::ACT_POP, 8'hFF, ibmh_pkg::INF_DIST);
        push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_GET, 8'd255, 31'd0);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd255, 31'd5);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd7, 31'd5);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd7, 31'd100);
        push_cmd(ibmh_pkg::ACT_GET, 8'd7, 31'd0);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd128, 31'h5555_5555);
        push_cmd(ibmh_pkg::ACT_DEC, 8'd129, 31'h2AAA_AAAA);
        push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_INIT, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
        push_cmd(ibmh_pkg::ACT_GET, 8'd0, 31'd0);
        // sender holds off until the block has drained
        drain();

        random_phase(120);
        drain();
        foreach (cfgs[i]) begin
            write_node_count(cfgs[i]);
            no_idle = (i % 4 == 2);
            if (cfgs[i] == 1) begin
                push_cmd(ibmh_pkg::ACT_INIT, 8'd1, 31'd0);
                push_cmd(ibmh_pkg::ACT_INIT, 8'd0, 31'd0);
                push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
                push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
            end
            random_phase(cfgs[i] >= 256 ? 80 : 115);
            // pop a small heap fully so the empty case recurs
            if (cfgs[i] > 0 && cfgs[i] <= 16)
                for (int j = 0; j <= cfgs[i]; j++)
                    push_cmd(ibmh_pkg::ACT_POP, 8'd0, 31'd0);
            drain();
        end
        no_idle = 0;
        write_node_count(256);
        random_phase(60);
        drain();
        repeat (50) @(posedge clk);

        if (fail_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

    initial begin
        #200ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
